// File: hdl/iirl_pkg.sv
// shared types, sizes and codes for the indexed insert/remove list
`default_nettype none

package iirl_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // fixed beat field widths
  localparam int ACTION_W  = 2;
  localparam int INDEX_W   = 5;
  localparam int ELEMENT_W = 32;
  localparam int STATUS_W  = 2;
  localparam int RVALUE_W  = 32;
  localparam int COUNT_W   = 5;

  // internal count and compare widths
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [INDEX_W-1:0]   index;
    logic [ELEMENT_W-1:0] element;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RVALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic                is_full;
  } out_beat_t;

  // command broadcast from the control unit to every cell
  typedef struct packed {
    logic                  shift_up;
    logic                  shift_down;
    logic                  read_en;
    logic [CMP_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] elem;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/iirl_cell.sv
// one list slot: holds an entry and shifts with its neighbors
`default_nettype none

module iirl_cell import iirl_pkg::*; (
  input  wire logic                  clk_i,
  input  wire cmd_t                  cmd_i,
  input  wire logic [CMP_W-1:0]      my_pos_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  input  wire logic [DATA_WIDTH-1:0] acc_i,
  output logic      [DATA_WIDTH-1:0] data_o,
  output logic      [DATA_WIDTH-1:0] acc_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  hit;

  assign hit = (my_pos_i == cmd_i.pos);

  always_comb begin
    data_d = data_q;
    if (cmd_i.shift_up) begin
      if (hit) begin
        data_d = cmd_i.elem;
      end else if (my_pos_i > cmd_i.pos) begin
        data_d = left_i;
      end
    end else if (cmd_i.shift_down && (my_pos_i >= cmd_i.pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // read result travels along the row
  assign acc_o  = (cmd_i.read_en && hit) ? (acc_i | data_q) : acc_i;

endmodule

`default_nettype wire

// File: hdl/iirl_ctrl.sv
// fill count and action checks, issues shift and read commands to the cells
`default_nettype none

module iirl_ctrl import iirl_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire in_beat_t             beat_i,
  output cmd_t                      cmd_o,
  output logic      [STATUS_W-1:0]  status_o,
  output logic      [CNT_W-1:0]     count_o,
  output logic      [CNT_W-1:0]     count_next_o
);

  logic [CNT_W-1:0]    count_q, count_d;
  logic [CMP_W-1:0]    idx, cnt;
  logic                ins, rem, rd;
  logic [STATUS_W-1:0] status;

  assign idx = CMP_W'(beat_i.index);
  assign cnt = CMP_W'(count_q);

  always_comb begin
    status = ST_DONE;
    ins    = 1'b0;
    rem    = 1'b0;
    rd     = 1'b0;
    case (beat_i.action)
      ACT_INSERT: begin
        if (count_q == CNT_W'(CAPACITY)) begin
          status = ST_FULL;
        end else if (idx > cnt) begin
          status = ST_RANGE;
        end else begin
          ins = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (idx >= cnt) begin
          status = ST_RANGE;
        end else begin
          rem = 1'b1;
        end
      end
      ACT_READ: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (idx >= cnt) begin
          status = ST_RANGE;
        end else begin
          rd = 1'b1;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign cmd_o.shift_up   = accept_i && ins;
  assign cmd_o.shift_down = accept_i && rem;
  assign cmd_o.read_en    = rd;
  assign cmd_o.pos        = idx;
  assign cmd_o.elem       = DATA_WIDTH'(beat_i.element);

  assign status_o     = status;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

`default_nettype wire

// File: hdl/indexed_insert_remove_list.sv
// top level: ordered list of entries built as a row of shifting cells
`default_nettype none

//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  in      | to block  | in_valid_i / in_stall_o | in_beat_i  (in_beat_t)
//  out     | from block| out_valid_o / out_stall_i| out_beat_o (out_beat_t)
//
//  one beat in, one beat out; the result shows the cycle after acceptance
//  every action is applied to all cells in parallel: each cell compares its position
//  with the index and takes its left or right neighbor or the new element
//  sustained rate is one beat per cycle while the output is not stalled
//  reset clears the fill count; the cell contents stay undefined until written
//  a stalled output holds its beat and the input stalls only while it does

module indexed_insert_remove_list import iirl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_beat_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_beat_o
);

  logic                  accept;
  cmd_t                  cmd;
  logic [STATUS_W-1:0]   status;
  logic [CNT_W-1:0]      count_cur;
  logic [CNT_W-1:0]      count_next;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] acc       [CAPACITY+1];

  logic                  out_valid_q, out_valid_d;
  out_beat_t             out_beat_q, out_beat_d;

  // input is taken whenever the output register is free or being emptied
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  iirl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .beat_i       (in_beat_i),
    .cmd_o        (cmd),
    .status_o     (status),
    .count_o      (count_cur),
    .count_next_o (count_next)
  );

  // row of cells, position 0 at the head of the list
  assign acc[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;

    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    iirl_cell u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .my_pos_i (CMP_W'(g)),
      .left_i   (left_w),
      .right_i  (right_w),
      .acc_i    (acc[g]),
      .data_o   (cell_data[g]),
      .acc_o    (acc[g+1])
    );
  end

  // result beat built from the checks and the post-action count
  always_comb begin
    out_beat_d.status     = status;
    out_beat_d.read_value = RVALUE_W'(acc[CAPACITY]);
    out_beat_d.count      = COUNT_W'(count_next);
    out_beat_d.is_empty   = (count_next == '0);
    out_beat_d.is_full    = (count_next == CNT_W'(CAPACITY));
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // fill count never goes past the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_cur <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // a completed insert grows the list by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_beat_i.action == ACT_INSERT) && (status == ST_DONE)
    |=> count_cur == $past(count_cur) + CNT_W'(1))
    else $error("insert did not grow the list");

  // a rejected action leaves the count alone
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (status != ST_DONE) |=> $stable(count_cur))
    else $error("rejected action changed the count");

  // an accepted beat always shows up on the output next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted beat produced no result");

endmodule

`default_nettype wire
